// ----- rtl/core/usod_pkg.sv -----
`default_nettype none
package usod_pkg;

    localparam int WINDOW   = 25;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW);
    localparam int SCAN_W   = $clog2(WINDOW + 1);

    localparam int WIDTH_W  = 16;
    localparam int TIME_W   = 32;
    localparam int DIST_W   = 11;
    localparam int RUN_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int TOL_W    = 8;
    localparam int SUM_W    = DIST_W + CNT_W;
    localparam int EV_W     = DIST_W + CNT_W;

    // distance = floor(width * 17 / 1000) = (width * 17 * ceil(2^30 / 1000)) >> 30
    localparam int MULT_W     = 25;
    localparam int DIST_SHIFT = 30;
    localparam int PROD_W     = WIDTH_W + MULT_W;
    localparam logic [MULT_W-1:0] DIST_MULT = 25'd18253614;

    localparam int REG_COUNT = 5;
    localparam int ADDR_W    = $clog2(4 * REG_COUNT);
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CLOSE_LIMIT = 3'd0,
        REG_RUN_NEEDED  = 3'd1,
        REG_PERIOD      = 3'd2,
        REG_PAIR_TOL    = 3'd3,
        REG_STUCK_TOL   = 3'd4
    } t_reg_idx;

    localparam logic [DIST_W-1:0]   RST_CLOSE_LIMIT = 11'd39;
    localparam logic [RUN_W-1:0]    RST_RUN_NEEDED  = 8'd7;
    localparam logic [PERIOD_W-1:0] RST_PERIOD      = 16'd6000;
    localparam logic [TOL_W-1:0]    RST_PAIR_TOL    = 8'd3;
    localparam logic [TOL_W-1:0]    RST_STUCK_TOL   = 8'd1;

    typedef struct packed {
        logic [DIST_W-1:0]   close_limit_cm;
        logic [RUN_W-1:0]    close_run_needed;
        logic [PERIOD_W-1:0] check_period_ms;
        logic [TOL_W-1:0]    pair_tolerance_cm;
        logic [TOL_W-1:0]    stuck_tolerance_cm;
    } t_cfg;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CALC = 6'b000010,
        S_UPD  = 6'b000100,
        S_SCAN = 6'b001000,
        S_EVAL = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/usod_in_if.sv -----
`default_nettype none
interface usod_in_if;
    import usod_pkg::*;

    logic                valid;
    logic                ready;
    logic [WIDTH_W-1:0]  echo_width_us;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output echo_width_us, output now_ms, input ready);
    modport sink   (input valid, input echo_width_us, input now_ms, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/usod_out_if.sv -----
`default_nettype none
interface usod_out_if;
    import usod_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance_cm;
    logic               stop_request;
    logic               stuck_alert;
    logic               check_done;

    modport source (output valid, output distance_cm, output stop_request,
                    output stuck_alert, output check_done, input ready);
    modport sink   (input valid, input distance_cm, input stop_request,
                    input stuck_alert, input check_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/usod_regs.sv -----
`default_nettype none
module usod_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [usod_pkg::ADDR_W-1:0] paddr,
    input  wire logic [usod_pkg::DATA_W-1:0] pwdata,
    output logic      [usod_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output usod_pkg::t_cfg                   o_cfg
);
    import usod_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_CLOSE_LIMIT: n_cfg.close_limit_cm     = pwdata[DIST_W-1:0];
                REG_RUN_NEEDED:  n_cfg.close_run_needed   = pwdata[RUN_W-1:0];
                REG_PERIOD:      n_cfg.check_period_ms    = pwdata[PERIOD_W-1:0];
                REG_PAIR_TOL:    n_cfg.pair_tolerance_cm  = pwdata[TOL_W-1:0];
                REG_STUCK_TOL:   n_cfg.stuck_tolerance_cm = pwdata[TOL_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CLOSE_LIMIT: prdata = DATA_W'(r_cfg.close_limit_cm);
            REG_RUN_NEEDED:  prdata = DATA_W'(r_cfg.close_run_needed);
            REG_PERIOD:      prdata = DATA_W'(r_cfg.check_period_ms);
            REG_PAIR_TOL:    prdata = DATA_W'(r_cfg.pair_tolerance_cm);
            REG_STUCK_TOL:   prdata = DATA_W'(r_cfg.stuck_tolerance_cm);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.close_limit_cm     <= RST_CLOSE_LIMIT;
            r_cfg.close_run_needed   <= RST_RUN_NEEDED;
            r_cfg.check_period_ms    <= RST_PERIOD;
            r_cfg.pair_tolerance_cm  <= RST_PAIR_TOL;
            r_cfg.stuck_tolerance_cm <= RST_STUCK_TOL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/ultrasonic_stall_and_obstacle_detector.sv -----
`default_nettype none
// An accepted input passes states CALC, UPD and OUT, with SCAN and EVAL after UPD when a
// stuck check runs; OUT holds while the last result is not taken, and new input is taken
// only in IDLE. The check reads the sample ring one entry a cycle through its single read port.
// Reset (synchronous, active low): registers to defaults, ring entries read as zero,
// run count, write index and last check time cleared, output empty.
module ultrasonic_stall_and_obstacle_detector (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    usod_in_if.sink                          i_in_ch,
    usod_out_if.source                       o_out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [usod_pkg::ADDR_W-1:0] paddr,
    input  wire logic [usod_pkg::DATA_W-1:0] pwdata,
    output logic      [usod_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import usod_pkg::*;

    t_cfg w_cfg;

    usod_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    t_state               r_state, n_state;
    logic [WIDTH_W-1:0]   r_width, n_width;
    logic [TIME_W-1:0]    r_now, n_now;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [DIST_W-1:0]    r_dist, n_dist;
    logic                 r_stop, n_stop;
    logic                 r_done, n_done;
    logic                 r_stuck, n_stuck;
    logic [RUN_W-1:0]     r_run_cnt, n_run_cnt;
    logic [IDX_W-1:0]     r_widx, n_widx;
    logic [TIME_W-1:0]    r_last, n_last;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic [SCAN_W-1:0]    r_scnt, n_scnt;
    logic [DIST_W-1:0]    r_prev, n_prev;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_pcnt, n_pcnt;
    logic                 r_out_valid, n_out_valid;
    logic [DIST_W-1:0]    r_out_dist, n_out_dist;
    logic                 r_out_stop, n_out_stop;
    logic                 r_out_stuck, n_out_stuck;
    logic                 r_out_done, n_out_done;

    logic [DIST_W-1:0]    r_ring [WINDOW];
    logic [WINDOW-1:0]    r_valid;
    logic [DIST_W-1:0]    r_rd_data;
    logic                 r_rd_vld;

    logic                 w_wr_en;
    logic [DIST_W-1:0]    w_dist;
    logic [DIST_W-1:0]    w_samp;
    logic [DIST_W-1:0]    w_pair_diff;
    logic [RUN_W-1:0]     w_run_inc;
    logic [TIME_W-1:0]    w_elapsed;
    logic [IDX_W-1:0]     w_widx_nxt;
    logic [IDX_W-1:0]     w_addr_nxt;
    logic [EV_W-1:0]      w_ev_sum;
    logic [EV_W-1:0]      w_ev_rhs;
    logic [EV_W-1:0]      w_ev_diff;
    logic [EV_W-1:0]      w_ev_tol;

    assign w_dist      = r_prod[DIST_SHIFT +: DIST_W];
    assign w_samp      = r_rd_vld ? r_rd_data : '0;
    assign w_pair_diff = (r_prev >= w_samp) ? (r_prev - w_samp) : (w_samp - r_prev);
    assign w_run_inc   = (r_run_cnt == {RUN_W{1'b1}}) ? r_run_cnt : r_run_cnt + 1'b1;
    assign w_elapsed   = r_now - r_last;
    assign w_widx_nxt  = (r_widx == IDX_W'(WINDOW - 1)) ? '0 : r_widx + 1'b1;
    assign w_addr_nxt  = (r_addr == IDX_W'(WINDOW - 1)) ? '0 : r_addr + 1'b1;
    assign w_ev_sum    = EV_W'(r_sum);
    assign w_ev_rhs    = EV_W'(r_dist) * EV_W'(r_pcnt);
    assign w_ev_diff   = (w_ev_sum >= w_ev_rhs) ? (w_ev_sum - w_ev_rhs)
                                                : (w_ev_rhs - w_ev_sum);
    assign w_ev_tol    = EV_W'(w_cfg.stuck_tolerance_cm) * EV_W'(r_pcnt);

    assign i_in_ch.ready         = (r_state == S_IDLE);
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.distance_cm  = r_out_dist;
    assign o_out_ch.stop_request = r_out_stop;
    assign o_out_ch.stuck_alert  = r_out_stuck;
    assign o_out_ch.check_done   = r_out_done;

    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_now       = r_now;
        n_prod      = r_prod;
        n_dist      = r_dist;
        n_stop      = r_stop;
        n_done      = r_done;
        n_stuck     = r_stuck;
        n_run_cnt   = r_run_cnt;
        n_widx      = r_widx;
        n_last      = r_last;
        n_addr      = r_addr;
        n_scnt      = r_scnt;
        n_prev      = r_prev;
        n_sum       = r_sum;
        n_pcnt      = r_pcnt;
        n_out_valid = r_out_valid;
        n_out_dist  = r_out_dist;
        n_out_stop  = r_out_stop;
        n_out_stuck = r_out_stuck;
        n_out_done  = r_out_done;
        w_wr_en     = 1'b0;

        if (r_out_valid && o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_ch.valid) begin
                    n_width = i_in_ch.echo_width_us;
                    n_now   = i_in_ch.now_ms;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_prod  = PROD_W'(r_width) * DIST_MULT;
                n_state = S_UPD;
            end
            S_UPD: begin
                w_wr_en = 1'b1;
                n_dist  = w_dist;
                n_stop  = 1'b0;
                if (w_dist <= w_cfg.close_limit_cm) begin
                    if (w_run_inc >= w_cfg.close_run_needed) begin
                        n_stop    = 1'b1;
                        n_run_cnt = '0;
                    end else begin
                        n_run_cnt = w_run_inc;
                    end
                end else begin
                    n_run_cnt = '0;
                end
                n_widx = w_widx_nxt;
                // oldest entry sits right after the one just written
                n_addr = w_widx_nxt;
                if (w_elapsed > TIME_W'(w_cfg.check_period_ms)) begin
                    n_done  = 1'b1;
                    n_last  = r_now;
                    n_scnt  = '0;
                    n_sum   = '0;
                    n_pcnt  = '0;
                    n_state = S_SCAN;
                end else begin
                    n_done  = 1'b0;
                    n_stuck = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                n_addr = w_addr_nxt;
                n_scnt = r_scnt + 1'b1;
                if (r_scnt != '0) begin
                    n_prev = w_samp;
                end
                if (r_scnt >= SCAN_W'(2) &&
                    DIST_W'(w_pair_diff) < DIST_W'(w_cfg.pair_tolerance_cm)) begin
                    n_sum  = r_sum + SUM_W'(r_prev);
                    n_pcnt = r_pcnt + 1'b1;
                end
                if (r_scnt == SCAN_W'(WINDOW)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // no qualifying pair gives a zero bound, so never stuck
                n_stuck = (w_ev_diff < w_ev_tol);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out_ch.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = r_dist;
                    n_out_stop  = r_stop;
                    n_out_stuck = r_stuck;
                    n_out_done  = r_done;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[r_widx] <= w_dist;
        end
        r_rd_data <= r_ring[r_addr];
        r_rd_vld  <= r_valid[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_cnt   <= '0;
            r_widx      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_run_cnt   <= n_run_cnt;
            r_widx      <= n_widx;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (w_wr_en) begin
                r_valid[r_widx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_width     <= n_width;
        r_now       <= n_now;
        r_prod      <= n_prod;
        r_dist      <= n_dist;
        r_stop      <= n_stop;
        r_done      <= n_done;
        r_stuck     <= n_stuck;
        r_addr      <= n_addr;
        r_scnt      <= n_scnt;
        r_prev      <= n_prev;
        r_sum       <= n_sum;
        r_pcnt      <= n_pcnt;
        r_out_dist  <= n_out_dist;
        r_out_stop  <= n_out_stop;
        r_out_stuck <= n_out_stuck;
        r_out_done  <= n_out_done;
    end

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= IDX_W'(WINDOW - 1))
        else $error("ring write index out of range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scnt <= SCAN_W'(WINDOW)))
        else $error("scan ran past the ring");

    a_pair_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_pcnt <= CNT_W'(WINDOW - 1)))
        else $error("more qualifying pairs than ring pairs");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && (w_dist <= w_cfg.close_limit_cm) &&
        (w_run_inc >= w_cfg.close_run_needed) |=> (r_stop && r_run_cnt == '0))
        else $error("stop request without cleared run count");

    a_check_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_last == r_now && r_done))
        else $error("check time not taken at check start");

endmodule
`default_nettype wire

// ----- tb/usod_reading_checker.sv -----
module usod_reading_checker
    import usod_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    usod_in_if                     i_in_ch,
    usod_out_if                    i_out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic              pready,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic              stop_request;
        logic              stuck_alert;
        logic              check_done;
    } t_reading;

    t_cfg               cfg;
    logic [DIST_W-1:0]  ring [WINDOW];
    logic [IDX_W-1:0]   wr_idx;
    logic [RUN_W-1:0]   close_run;
    logic [TIME_W-1:0]  last_check;
    t_reading           expected_readings [$];
    int                 mismatches = 0;

    // oldest to newest walk over the ring, exact mean compare without division
    function automatic logic stall_detected();
        int unsigned       start;
        int unsigned       newest;
        int unsigned       a;
        int unsigned       b;
        int unsigned       count;
        longint unsigned   sum;
        longint unsigned   prod;
        longint unsigned   diff;
        start  = wr_idx;
        newest = ring[(start + WINDOW - 1) % WINDOW];
        sum    = 0;
        count  = 0;
        for (int k = 0; k < WINDOW - 1; k++) begin
            a = ring[(start + k) % WINDOW];
            b = ring[(start + k + 1) % WINDOW];
            if (((a >= b) ? a - b : b - a) < cfg.pair_tolerance_cm) begin
                sum   += a;
                count++;
            end
        end
        if (count == 0)
            return 1'b0;
        prod = longint'(newest) * count;
        diff = (sum >= prod) ? sum - prod : prod - sum;
        return diff < longint'(cfg.stuck_tolerance_cm) * count;
    endfunction

    function automatic t_reading predict_reading(input logic [WIDTH_W-1:0] width,
                                                 input logic [TIME_W-1:0] now);
        t_reading          r;
        int unsigned       dist_cm;
        logic [TIME_W-1:0] elapsed;
        r       = '0;
        dist_cm = (int'(width) * 17) / 1000;
        if (dist_cm > 2047)
            dist_cm = 2047;
        r.distance_cm = DIST_W'(dist_cm);
        if (dist_cm <= cfg.close_limit_cm) begin
            if (close_run != '1)
                close_run++;
            if (close_run >= cfg.close_run_needed) begin
                r.stop_request = 1'b1;
                close_run      = '0;
            end
        end else begin
            close_run = '0;
        end
        ring[wr_idx] = DIST_W'(dist_cm);
        wr_idx       = (wr_idx == IDX_W'(WINDOW - 1)) ? '0 : wr_idx + 1'b1;
        elapsed = now - last_check;
        if (elapsed > cfg.check_period_ms) begin
            r.check_done  = 1'b1;
            r.stuck_alert = stall_detected();
            last_check    = now;
        end
        return r;
    endfunction

    task automatic report(input string what, input t_reading exp, input t_reading got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                     $time, what, exp.distance_cm, exp.stop_request, exp.stuck_alert,
                     exp.check_done, got.distance_cm, got.stop_request, got.stuck_alert,
                     got.check_done);
    endtask

    always @(posedge i_clk) begin
        t_reading exp;
        t_reading got;
        t_reading pred;
        if (!i_rst_n) begin
            cfg.close_limit_cm     = RST_CLOSE_LIMIT;
            cfg.close_run_needed   = RST_RUN_NEEDED;
            cfg.check_period_ms    = RST_PERIOD;
            cfg.pair_tolerance_cm  = RST_PAIR_TOL;
            cfg.stuck_tolerance_cm = RST_STUCK_TOL;
            for (int i = 0; i < WINDOW; i++)
                ring[i] = '0;
            wr_idx     = '0;
            close_run  = '0;
            last_check = '0;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_CLOSE_LIMIT: cfg.close_limit_cm     = pwdata[DIST_W-1:0];
                    REG_RUN_NEEDED:  cfg.close_run_needed   = pwdata[RUN_W-1:0];
                    REG_PERIOD:      cfg.check_period_ms    = pwdata[PERIOD_W-1:0];
                    REG_PAIR_TOL:    cfg.pair_tolerance_cm  = pwdata[TOL_W-1:0];
                    REG_STUCK_TOL:   cfg.stuck_tolerance_cm = pwdata[TOL_W-1:0];
                    default: ;
                endcase
            end
            // result side first: a result never belongs to an input of the same edge
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.distance_cm  = i_out_ch.distance_cm;
                got.stop_request = i_out_ch.stop_request;
                got.stuck_alert  = i_out_ch.stuck_alert;
                got.check_done   = i_out_ch.check_done;
                if (expected_readings.size() == 0) begin
                    report("result transfer with nothing pending", '0, got);
                end else begin
                    exp = expected_readings.pop_front();
                    if (got.distance_cm !== exp.distance_cm ||
                        got.stop_request !== exp.stop_request ||
                        got.stuck_alert !== exp.stuck_alert ||
                        got.check_done !== exp.check_done)
                        report("result mismatch", exp, got);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                pred = predict_reading(i_in_ch.echo_width_us, i_in_ch.now_ms);
                expected_readings = {expected_readings, pred};
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import usod_pkg::*;

    typedef enum {SEG_STEADY, SEG_RAMP, SEG_NOISE} t_seg_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    bit                calm = 1'b0;

    logic [TIME_W-1:0] clock_ms = '0;
    int unsigned       base_width;
    int unsigned       jitter;
    int unsigned       ramp_step;
    int unsigned       seg_left = 0;
    t_seg_mode         seg_mode = SEG_STEADY;

    usod_in_if  in_ch ();
    usod_out_if out_ch ();

    ultrasonic_stall_and_obstacle_detector uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    usod_reading_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned limit, input int unsigned run,
                              input int unsigned period, input int unsigned pair_tol,
                              input int unsigned stuck_tol);
        write_reg(REG_CLOSE_LIMIT, limit);
        write_reg(REG_RUN_NEEDED, run);
        write_reg(REG_PERIOD, period);
        write_reg(REG_PAIR_TOL, pair_tol);
        write_reg(REG_STUCK_TOL, stuck_tol);
    endtask

    task automatic send_reading(input logic [WIDTH_W-1:0] width,
                                input logic [TIME_W-1:0] now);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.echo_width_us <= width;
        in_ch.now_ms        <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // segments of steady, approaching or noisy readings over a mostly advancing clock
    task automatic make_reading(output logic [WIDTH_W-1:0] width,
                                output logic [TIME_W-1:0] now);
        int unsigned r;
        int unsigned w;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = $urandom;
        else if (r < 8)
            clock_ms += $urandom_range(0, 70000);
        else
            clock_ms += $urandom_range(0, 300);
        if (seg_left == 0) begin
            seg_left = $urandom_range(5, 40);
            r = $urandom_range(0, 9);
            if (r < 6)
                seg_mode = SEG_STEADY;
            else if (r < 8)
                seg_mode = SEG_RAMP;
            else
                seg_mode = SEG_NOISE;
            base_width = $urandom_range(0, 1) ? $urandom_range(0, 3000)
                                              : $urandom_range(0, 65535);
            jitter     = $urandom_range(0, 1) ? $urandom_range(0, 60)
                                              : $urandom_range(0, 400);
            ramp_step  = $urandom_range(0, 400);
        end
        seg_left--;
        case (seg_mode)
            SEG_STEADY: begin
                w = base_width + $urandom_range(0, 2 * jitter);
                w = (w > jitter) ? w - jitter : 0;
            end
            SEG_RAMP: begin
                base_width = (base_width > ramp_step) ? base_width - ramp_step
                                                      : $urandom_range(0, 65535);
                w = base_width;
            end
            default: w = $urandom_range(0, 65535);
        endcase
        if (w > 65535)
            w = 65535;
        width = WIDTH_W'(w);
        now   = clock_ms;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n);
        logic [WIDTH_W-1:0] w;
        logic [TIME_W-1:0]  t;
        repeat (n) begin
            make_reading(w, t);
            send_reading(w, t);
        end
        drain();
    endtask

    initial begin
        int unsigned r;
        out_ch.ready <= 1'b0;
        forever begin
            if (calm) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 4);
                if (r == 0) begin
                    out_ch.ready <= 1'b1;
                    repeat ($urandom_range(30, 80)) @(posedge i_clk);
                end else begin
                    out_ch.ready <= 1'($urandom_range(0, 1));
                    repeat ($urandom_range(1, 14)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.echo_width_us <= '0;
        in_ch.now_ms        <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared ring, field extremes, close run, limit boundary, time wrap
        send_reading(16'd0, 32'd6001);
        send_reading(16'hFFFF, 32'd6001);
        send_reading(16'd58, 32'hFFFF_FFFF);
        send_reading(16'd59, 32'd3);
        for (int i = 0; i < 7; i++)
            send_reading(16'd2352, 32'd4 + i);
        send_reading(16'd2353, 32'd11);
        send_reading(16'd2352, 32'd12);
        send_reading(16'd0, 32'd6002);
        send_reading(16'd0, 32'd12002);
        send_reading(16'd0, 32'd12003);
        send_reading(16'hAAAA, 32'h5555_5555);
        send_reading(16'h5555, 32'hAAAA_AAAA);
        clock_ms = 32'hAAAA_AAAA;
        run_phase(60);

        set_config(2047, 0, 0, 255, 255);
        run_phase(80);
        set_config(0, 255, 65535, 0, 0);
        run_phase(80);
        set_config(100, 1, 50, 5, 3);
        run_phase(100);
        set_config(2047, 255, 200, 1, 1);
        run_phase(280);
        set_config($urandom_range(0, 2047), $urandom_range(0, 255), $urandom_range(0, 65535),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        run_phase(80);
        set_config(60, 3, 1000, 2, 1);
        run_phase(80);
        calm = 1'b1;
        set_config($urandom_range(0, 2047), $urandom_range(1, 255), $urandom_range(0, 2000),
                   $urandom_range(1, 255), $urandom_range(1, 255));
        run_phase(60);

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
